[hdl/mtrr_memory_type_resolver_unit_defines.svh]
// Assertion macros for the MTRR memory type resolver.
`ifndef MTRR_MEMORY_TYPE_RESOLVER_UNIT_DEFINES_SVH
`define MTRR_MEMORY_TYPE_RESOLVER_UNIT_DEFINES_SVH

// same-cycle implication
`define MTRR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTRR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/mtrr_pkg.sv]
// Package: types, codes and constants of the MTRR memory type resolver.
`timescale 1ns / 1ps
package mtrr_pkg;

   localparam int ADDR_W         = 52;
   localparam int PFN_LO         = 12;
   localparam int PFN_W          = ADDR_W - PFN_LO;
   localparam int VAR_RANGES_DEF = 8;
   localparam int FIXED_WORDS    = 11;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 6;
   localparam int MASK_VALID_BIT = 11;

   localparam logic [5:0] PA_MIN   = 6'd32;
   localparam logic [5:0] PA_MAX   = 6'd52;
   localparam logic [5:0] PA_RESET = 6'd36;

   localparam logic [1:0] OP_QUERY    = 2'd0;
   localparam logic [1:0] OP_WR_FIXED = 2'd1;
   localparam logic [1:0] OP_WR_VAR   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SUPPORTED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_EN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_TYPE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VAR_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PA_BITS   = 3'd5;

   localparam logic [2:0] TYPE_UC = 3'd0;
   localparam logic [2:0] TYPE_WC = 3'd1;
   localparam logic [2:0] TYPE_WT = 3'd4;
   localparam logic [2:0] TYPE_WP = 3'd5;
   localparam logic [2:0] TYPE_WB = 3'd6;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] region_base;
      logic [ADDR_W-1:0] region_mask;
      logic [3:0]        entry_index;
      logic [63:0]       word_a;
      logic [63:0]       word_b;
   } req_type;

   typedef struct packed {
      logic [2:0] mem_attr;
      logic       partial_overlap;
   } rsp_type;

   // running scan status handed from cell to cell
   typedef struct packed {
      logic       done;
      logic       have;
      logic [2:0] cand;
      logic [2:0] res_type;
      logic       partial;
   } tok_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELIVER
   } state_type;

   function automatic logic type_is_valid(input logic [7:0] t);
      return t == {5'd0, TYPE_UC} || t == {5'd0, TYPE_WC} || t == {5'd0, TYPE_WT} ||
             t == {5'd0, TYPE_WP} || t == {5'd0, TYPE_WB};
   endfunction

endpackage

[hdl/mtrr_memory_type_resolver_unit.sv]
// Top level: MTRR memory type resolver with a chain of variable-range cells.
// Query: ST_SCAN passes the status token through one variable-range cell per cycle,
// then ST_DELIVER; write items and unused ops go straight from ST_IDLE to ST_DELIVER.
// One item in flight: the next request is taken once the previous result sits in the
// output register.
// Synchronous reset clears control, configuration, fixed words and cell valid bits.
`timescale 1ns / 1ps
module mtrr_memory_type_resolver_unit
   import mtrr_pkg::*;
#(
   parameter int VAR_RANGES = VAR_RANGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(VAR_RANGES + 1);

   logic       supported_ff;
   logic       enable_ff;
   logic       fixed_en_ff;
   logic [2:0] def_type_ff;
   logic [3:0] var_count_ff;
   logic [5:0] pa_bits_ff;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] base_ff;
   logic [ADDR_W-1:0] mask_ff;
   rsp_type           pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic [5:0]        pa_sat;
   logic [ADDR_W-1:0] above;
   logic              slot_hit;
   logic [2:0]        slot_type;
   logic              mtrr_on;
   logic              fix_take;
   tok_type           head_tok;
   tok_type           tok [VAR_RANGES + 1];
   tok_type           tail;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         supported_ff <= 1'b0;
         enable_ff    <= 1'b0;
         fixed_en_ff  <= 1'b0;
         def_type_ff  <= 3'd0;
         var_count_ff <= 4'd0;
         pa_bits_ff   <= PA_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SUPPORTED: supported_ff <= csr_wdata[0];
            CSR_ENABLE:    enable_ff    <= csr_wdata[0];
            CSR_FIXED_EN:  fixed_en_ff  <= csr_wdata[0];
            CSR_DEF_TYPE:  def_type_ff  <= csr_wdata[2:0];
            CSR_VAR_COUNT: var_count_ff <= csr_wdata[3:0];
            CSR_PA_BITS:   pa_bits_ff   <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pa_bits_ff < PA_MIN) begin
         pa_sat = PA_MIN;
      end else if (pa_bits_ff > PA_MAX) begin
         pa_sat = PA_MAX;
      end else begin
         pa_sat = pa_bits_ff;
      end
      for (int k = 0; k < ADDR_W; k++) begin
         above[k] = (k >= int'(pa_sat));
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff <= req_data.region_base;
         mask_ff <= req_data.region_mask;
      end
   end

   mtrr_fixed_unit u_fixed (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (accept && req_data.op == OP_WR_FIXED),
      .wr_index    (req_data.entry_index),
      .wr_data     (req_data.word_a),
      .region_base (base_ff),
      .region_mask (mask_ff),
      .slot_hit    (slot_hit),
      .slot_type   (slot_type)
   );

   assign mtrr_on  = supported_ff && enable_ff;
   assign fix_take = mtrr_on && fixed_en_ff && slot_hit;

   always_comb begin
      head_tok          = '0;
      head_tok.done     = !mtrr_on || fix_take;
      head_tok.res_type = fix_take ? slot_type : TYPE_UC;
   end

   assign tok[0] = head_tok;

   for (genvar g = 0; g < VAR_RANGES; g++) begin : g_cell
      mtrr_var_cell #(
         .IDX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .wr_en       (accept && req_data.op == OP_WR_VAR),
         .wr_index    (req_data.entry_index),
         .wr_base     (req_data.word_a),
         .wr_mask     (req_data.word_b),
         .region_base (base_ff),
         .region_mask (mask_ff),
         .above       (above),
         .count       (var_count_ff),
         .tok_in      (tok[g]),
         .tok_out     (tok[g+1])
      );
   end

   assign tail = tok[VAR_RANGES];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cnt_in  = '0;
               pend_in = '0;
               if (req_data.op == OP_QUERY) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DELIVER;
               end
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VAR_RANGES)) begin
               if (tail.done) begin
                  pend_in.mem_attr        = tail.res_type;
                  pend_in.partial_overlap = tail.partial;
               end else begin
                  pend_in.mem_attr        = tail.have ? tail.cand : def_type_ff;
                  pend_in.partial_overlap = 1'b0;
               end
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/mtrr_fixed_unit.sv]
// Fixed-range MTRR words and first-MiB slot lookup.
`timescale 1ns / 1ps
module mtrr_fixed_unit
   import mtrr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [3:0]        wr_index,
   input  logic [63:0]       wr_data,
   input  logic [ADDR_W-1:0] region_base,
   input  logic [ADDR_W-1:0] region_mask,
   output logic              slot_hit,
   output logic [2:0]        slot_type
);

   logic [63:0] words_ff [FIXED_WORDS];
   logic [3:0]  word_sel;
   logic [2:0]  byte_sel;
   logic        mask_ok;
   logic [63:0] sel_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FIXED_WORDS; i++) begin
            words_ff[i] <= '0;
         end
      end else if (wr_en && (int'(wr_index) < FIXED_WORDS)) begin
         words_ff[wr_index] <= wr_data;
      end
   end

   // 64K slots below 0x80000, 16K below 0xC0000, 4K up to 1 MiB
   always_comb begin
      if (!region_base[19]) begin
         word_sel = 4'd0;
         byte_sel = region_base[18:16];
         mask_ok  = &region_mask[ADDR_W-1:16];
      end else if (!region_base[18]) begin
         word_sel = 4'd1 + {3'd0, region_base[17]};
         byte_sel = region_base[16:14];
         mask_ok  = &region_mask[ADDR_W-1:14];
      end else begin
         word_sel = 4'd3 + {1'b0, region_base[17:15]};
         byte_sel = region_base[14:12];
         mask_ok  = &region_mask[ADDR_W-1:12];
      end
   end

   assign sel_word  = words_ff[word_sel];
   assign slot_type = sel_word[{byte_sel, 3'b000} +: 3];
   assign slot_hit  = (region_base[ADDR_W-1:20] == '0) && mask_ok;

endmodule

[hdl/mtrr_var_cell.sv]
// One variable-range cell: holds a base/mask pair and updates the scan status.
`timescale 1ns / 1ps
module mtrr_var_cell
   import mtrr_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [3:0]        wr_index,
   input  logic [63:0]       wr_base,
   input  logic [63:0]       wr_mask,
   input  logic [ADDR_W-1:0] region_base,
   input  logic [ADDR_W-1:0] region_mask,
   input  logic [ADDR_W-1:0] above,
   input  logic [3:0]        count,
   input  tok_type           tok_in,
   output tok_type           tok_out
);

   logic             valid_ff;
   logic [PFN_W-1:0] base_pfn_ff;
   logic [PFN_W-1:0] mask_pfn_ff;
   logic [7:0]       type_ff;
   tok_type          tok_ff;
   tok_type          tok_in_next;

   logic [ADDR_W-1:0] vb;
   logic [ADDR_W-1:0] vm;
   logic              active;
   logic              contains;
   logic              disjoint;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en && int'(wr_index) == IDX) begin
         valid_ff <= wr_mask[MASK_VALID_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && int'(wr_index) == IDX) begin
         base_pfn_ff <= wr_base[ADDR_W-1:PFN_LO];
         mask_pfn_ff <= wr_mask[ADDR_W-1:PFN_LO];
         type_ff     <= wr_base[7:0];
      end
   end

   assign vb       = {base_pfn_ff, {PFN_LO{1'b0}}};
   assign vm       = {mask_pfn_ff, {PFN_LO{1'b0}}} | above;
   assign active   = !tok_in.done && (IDX < int'(count)) && valid_ff;
   assign contains = ((vm & ~region_mask) == '0) && (((vb ^ region_base) & vm) == '0);
   assign disjoint = ((vb ^ region_base) & vm & region_mask) != '0;

   always_comb begin
      tok_in_next = tok_in;
      if (active) begin
         if (contains) begin
            if (type_ff == {5'd0, TYPE_UC}) begin
               tok_in_next.done     = 1'b1;
               tok_in_next.res_type = TYPE_UC;
            end else if (type_ff == {5'd0, TYPE_WB} && tok_in.have &&
                         (tok_in.cand == TYPE_WT || tok_in.cand == TYPE_WB)) begin
               tok_in_next = tok_in;
            end else begin
               tok_in_next.have = type_is_valid(type_ff);
               tok_in_next.cand = type_ff[2:0];
            end
         end else if (!disjoint) begin
            tok_in_next.done     = 1'b1;
            tok_in_next.res_type = TYPE_UC;
            tok_in_next.partial  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in_next;
   end

   assign tok_out = tok_ff;

endmodule

[hdl/mtrr_checker.sv]
// Port-level checks for the MTRR memory type resolver, bound to the top level.
`timescale 1ns / 1ps
`include "mtrr_memory_type_resolver_unit_defines.svh"
module mtrr_checker
   import mtrr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `MTRR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")
   `MTRR_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request taken while a transfer is in progress")
   `MTRR_ASSERT_IMP(a_partial_uc, clock, reset, rsp_valid && rsp_data.partial_overlap, rsp_data.mem_attr == TYPE_UC, "partial overlap with a defined type")

endmodule

bind mtrr_memory_type_resolver_unit mtrr_checker u_mtrr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
